FILE: hw/rtl/avtp_audio_depacketizer_unit_defines.svh
// assertion helpers for the depacketizer unit
`ifndef AVTP_AUDIO_DEPACKETIZER_UNIT_DEFINES_SVH
`define AVTP_AUDIO_DEPACKETIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define AVTPAD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AVTPAD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/avtpad_pkg.sv
package avtpad_pkg;

  localparam int HDR_BYTES     = 24;
  localparam int MAX_PDU_BYTES = 1500;
  localparam int POS_W         = 11;
  localparam int HDR_AW        = 5;

  localparam int OFS_STREAM = 4;
  localparam int OFS_FORMAT = 12;
  localparam int OFS_RATE   = 13;
  localparam int OFS_FLAGS  = 14;
  localparam int OFS_SEQ    = 15;
  localparam int OFS_TS     = 16;
  localparam int TS_VALID_BIT = 7;

  localparam int THR_W       = 31;
  localparam int THR_SCALE   = 2000;
  localparam int THR_RESET   = 4000000;

  localparam int RF_DEPTH = 4;
  localparam int RF_AW    = 2;
  localparam int RF_CW    = 3;

  localparam logic [62:0] LAT_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [RF_CW-1:0] rf_cnt_t;
  typedef logic [RF_AW-1:0] rf_ptr_t;

  typedef enum logic [1:0] {
    CFG_STREAM_ID,
    CFG_SAMPLE_BYTES,
    CFG_RATE_CODE,
    CFG_PRES_OFFSET
  } cfg_idx_t;

  typedef enum logic [2:0] {
    STS_OK,
    STS_SHORT,
    STS_STREAM,
    STS_CODES,
    STS_MISALIGN,
    STS_EMPTY
  } sts_code_t;

  typedef struct packed {
    logic [7:0]  pdu_byte;
    logic        last_byte;
    logic [63:0] now_ns;
  } in_word_t;

  typedef struct packed {
    logic               is_status;
    logic signed [31:0] sample_value;
    logic [2:0]         status_code;
    logic               sequence_gap;
    logic               timestamp_bad;
    logic               skew_event;
    logic signed [63:0] latency_ns;
    logic [62:0]        max_latency_ns;
    logic [62:0]        min_latency_ns;
    logic [9:0]         sample_count;
    logic [63:0]        packet_timestamp;
    logic               last_result;
  } out_word_t;

  typedef struct packed {
    logic [63:0] stream_id;
    logic [2:0]  sample_bytes;
    logic [3:0]  rate_code;
  } cfg_t;

  // results of one accepted byte, ahead of the latency math
  typedef struct packed {
    logic        smp_v;
    logic [31:0] smp_val;
    logic        smp_last;
    logic        sts_v;
    sts_code_t   code;
    logic        seq_gap;
    logic        ts_bad;
    logic [63:0] ts;
    logic [63:0] now;
    logic [9:0]  cnt;
  } front_bndl_t;

  typedef struct packed {
    logic        smp_v;
    logic [31:0] smp_val;
    logic        smp_last;
    logic        sts_v;
    sts_code_t   code;
    logic        seq_gap;
    logic        ts_bad;
    logic        ts_zero;
    logic [63:0] ts;
    logic [63:0] lat;
    logic [63:0] mag;
    logic [9:0]  cnt;
  } lat_bndl_t;

  typedef struct packed {
    logic        smp_v;
    logic [31:0] smp_val;
    logic        smp_last;
    logic        sts_v;
    out_word_t   sts;
  } rf_ent_t;

endpackage

FILE: hw/rtl/avtp_audio_depacketizer_unit.sv
// AVTP audio depacketizer.
// in channel: one packet byte per word (pdu_byte, last_byte, now_ns), valid/stall.
// The first 24 bytes form the header; later bytes are packed into sign-extended
// big-endian samples, each sent as a word on the out channel as soon as it is
// complete. The last byte of a packet adds one status word (code, sequence,
// timestamp and latency checks, running max/min latency).
// cfg channel: valid/ready write of index and data; ready is always high, and
// writes are meant for times when no packet is in progress.
// Path: each result goes through the input stage, the latency subtract stage and
// then the result queue before it is offered on out.
// Throughput: one byte per cycle while in_stall is low; a last byte that also
// completes a sample yields two results, its sample word and then its status word.
// The 4-entry result queue with credit counting raises in_stall when queue and
// pipeline together hold four bundles, so a stalled receiver backs up to in.
// Reset (rst, synchronous) empties the pipeline and queue, restarts packet
// parsing, clears the expected sequence, resets the max/min latency and restores the configuration defaults.
`include "avtp_audio_depacketizer_unit_defines.svh"

module avtp_audio_depacketizer_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  avtpad_pkg::in_word_t    in_word,
  output logic                    out_valid,
  input  logic                    out_stall,
  output avtpad_pkg::out_word_t   out_word,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  avtpad_pkg::cfg_idx_t    cfg_index,
  input  logic [63:0]             cfg_data
);

  avtpad_pkg::cfg_t          cfg;
  logic [avtpad_pkg::THR_W-1:0] thr;

  logic                      in_acc;
  avtpad_pkg::front_bndl_t   p1;
  logic                      p1_v;
  avtpad_pkg::lat_bndl_t     p2;
  logic                      p2_v;
  logic [63:0]               lat_raw;

  logic [62:0]               max_lat;
  logic [62:0]               min_lat;
  logic [62:0]               max_lat_next;
  logic [62:0]               min_lat_next;
  logic                      upd;

  avtpad_pkg::rf_ent_t       rf [avtpad_pkg::RF_DEPTH];
  avtpad_pkg::rf_ptr_t       wr_ptr;
  avtpad_pkg::rf_ptr_t       rd_ptr;
  avtpad_pkg::rf_cnt_t       rf_cnt;
  avtpad_pkg::rf_cnt_t       used;
  logic                      sub_sel;
  avtpad_pkg::rf_ent_t       ent;
  avtpad_pkg::rf_ent_t       head;
  logic                      show_smp;
  logic                      out_acc;
  logic                      pop;
  avtpad_pkg::out_word_t     smp_out;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stream_id    <= '0;
      cfg.sample_bytes <= 3'd3;
      cfg.rate_code    <= 4'd5;
      thr              <= avtpad_pkg::THR_W'(avtpad_pkg::THR_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        avtpad_pkg::CFG_STREAM_ID:    cfg.stream_id    <= cfg_data;
        avtpad_pkg::CFG_SAMPLE_BYTES: cfg.sample_bytes <= cfg_data[2:0];
        avtpad_pkg::CFG_RATE_CODE:    cfg.rate_code    <= cfg_data[3:0];
        avtpad_pkg::CFG_PRES_OFFSET:
          thr <= avtpad_pkg::THR_W'(cfg_data[19:0]) *
                 avtpad_pkg::THR_W'(avtpad_pkg::THR_SCALE);
        default: ;
      endcase
    end
  end

  // input stage
  assign used = rf_cnt + avtpad_pkg::rf_cnt_t'(p1_v) + avtpad_pkg::rf_cnt_t'(p2_v);
  assign in_stall = used >= avtpad_pkg::rf_cnt_t'(avtpad_pkg::RF_DEPTH);
  assign in_acc   = in_valid && !in_stall;

  avtpad_front u_front (
    .clk     (clk),
    .rst     (rst),
    .acc     (in_acc),
    .in_word (in_word),
    .cfg     (cfg),
    .p1      (p1),
    .p1_v    (p1_v)
  );

  // latency subtract stage; both directions in parallel for the magnitude
  assign lat_raw = p1.now - p1.ts;

  always_ff @(posedge clk) begin
    p2.smp_v    <= p1.smp_v;
    p2.smp_val  <= p1.smp_val;
    p2.smp_last <= p1.smp_last;
    p2.sts_v    <= p1.sts_v;
    p2.code     <= p1.code;
    p2.seq_gap  <= p1.seq_gap;
    p2.ts_bad   <= p1.ts_bad;
    p2.ts_zero  <= p1.ts == 64'd0;
    p2.ts       <= p1.ts;
    p2.lat      <= lat_raw;
    // magnitude of the wrapped difference taken as signed
    p2.mag      <= lat_raw[63] ? p1.ts - p1.now : lat_raw;
    p2.cnt      <= p1.cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else begin
      p2_v <= p1_v;
    end
  end

  // running latency extremes, updated as the status enters the queue
  assign upd = p2_v && p2.sts_v && !p2.ts_zero && !p2.lat[63];
  assign max_lat_next = (upd && (p2.lat[62:0] > max_lat)) ? p2.lat[62:0] : max_lat;
  assign min_lat_next = (upd && (p2.lat[62:0] < min_lat)) ? p2.lat[62:0] : min_lat;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lat <= '0;
      min_lat <= avtpad_pkg::LAT_MAX;
    end else begin
      max_lat <= max_lat_next;
      min_lat <= min_lat_next;
    end
  end

  always_comb begin
    ent                      = '0;
    ent.smp_v                = p2.smp_v;
    ent.smp_val              = p2.smp_val;
    ent.smp_last             = p2.smp_last;
    ent.sts_v                = p2.sts_v;
    ent.sts.is_status        = 1'b1;
    ent.sts.status_code      = p2.code;
    ent.sts.sequence_gap     = p2.seq_gap;
    ent.sts.timestamp_bad    = p2.ts_bad;
    ent.sts.skew_event       = !p2.ts_zero && (p2.mag > 64'(thr));
    ent.sts.latency_ns       = p2.ts_zero ? 64'sd0 : $signed(p2.lat);
    ent.sts.max_latency_ns   = max_lat_next;
    ent.sts.min_latency_ns   = min_lat_next;
    ent.sts.sample_count     = p2.cnt;
    ent.sts.packet_timestamp = p2.ts;
    ent.sts.last_result      = 1'b1;
  end

  // result queue
  always_ff @(posedge clk) begin
    if (p2_v) begin
      rf[wr_ptr] <= ent;
    end
  end

  assign head      = rf[rd_ptr];
  assign out_valid = rf_cnt != '0;
  assign show_smp  = head.smp_v && !sub_sel;
  assign out_acc   = out_valid && !out_stall;
  assign pop       = out_acc && !(show_smp && head.sts_v);

  always_comb begin
    smp_out              = '0;
    smp_out.sample_value = $signed(head.smp_val);
    smp_out.last_result  = head.smp_last;
  end

  assign out_word = show_smp ? smp_out : head.sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      rf_cnt  <= '0;
      sub_sel <= 1'b0;
    end else begin
      if (p2_v) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr  <= rd_ptr + 1'b1;
        sub_sel <= 1'b0;
      end else if (out_acc) begin
        // sample word went out, status of the same bundle follows
        sub_sel <= 1'b1;
      end
      rf_cnt <= rf_cnt + avtpad_pkg::rf_cnt_t'(p2_v) - avtpad_pkg::rf_cnt_t'(pop);
    end
  end

  `AVTPAD_ASSERT_IMP(a_credit_bound, clk, rst, 1'b1, used <= avtpad_pkg::rf_cnt_t'(avtpad_pkg::RF_DEPTH), "result queue credits overrun")
  `AVTPAD_ASSERT_IMP(a_no_write_full, clk, rst, p2_v, rf_cnt < avtpad_pkg::rf_cnt_t'(avtpad_pkg::RF_DEPTH), "write into full result queue")
  `AVTPAD_ASSERT_NXT(a_last_gives_status, clk, rst, in_acc && in_word.last_byte, p1_v && p1.sts_v, "last byte without status bundle")
  `AVTPAD_ASSERT_IMP(a_sub_sel_pair, clk, rst, sub_sel, out_valid && head.smp_v && head.sts_v, "second half shown without paired bundle")
  `AVTPAD_ASSERT_IMP(a_min_le_max, clk, rst, min_lat != avtpad_pkg::LAT_MAX, min_lat <= max_lat, "latency minimum above maximum")

endmodule

FILE: hw/rtl/avtpad_front.sv
module avtpad_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     acc,
  input  avtpad_pkg::in_word_t     in_word,
  input  avtpad_pkg::cfg_t         cfg,
  output avtpad_pkg::front_bndl_t  p1,
  output logic                     p1_v
);

  logic [7:0]             hdr [avtpad_pkg::HDR_BYTES];
  avtpad_pkg::pos_t       pos;
  logic                   hdr_acc;
  logic                   hdr_stream_ok;
  logic [23:0]            smp_acc;
  logic [1:0]             bis;
  logic [9:0]             cnt;
  logic [7:0]             exp_seq;

  avtpad_pkg::pos_t       pos_next;
  logic                   active;
  logic                   in_hdr;
  logic                   hdr_done;
  logic [63:0]            hdr_sid;
  logic [63:0]            hdr_ts;
  logic                   stream_eq;
  logic                   size_ok;
  logic                   codes_ok;
  logic                   acc_now;
  logic                   stream_ok_now;
  logic                   pay;
  logic [2:0]             bis_inc;
  logic                   smp_done;
  logic [31:0]            smp_word;
  logic [31:0]            smp_val;
  logic [1:0]             bis_next;
  logic [23:0]            smp_acc_next;
  logic [9:0]             cnt_next;
  logic                   short_pkt;
  logic                   detail;
  avtpad_pkg::sts_code_t  code;
  avtpad_pkg::front_bndl_t bndl;

  assign active   = pos < avtpad_pkg::pos_t'(avtpad_pkg::MAX_PDU_BYTES);
  assign in_hdr   = pos < avtpad_pkg::pos_t'(avtpad_pkg::HDR_BYTES);
  assign hdr_done = pos == avtpad_pkg::pos_t'(avtpad_pkg::HDR_BYTES - 1);
  assign pos_next = active ? pos + 1'b1 : pos;

  // big-endian header fields; the last timestamp byte may be the one arriving now
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hdr_sid[63 - 8*i -: 8] = hdr[avtpad_pkg::OFS_STREAM + i];
      hdr_ts[63 - 8*i -: 8]  = hdr[avtpad_pkg::OFS_TS + i];
    end
    if (hdr_done) begin
      hdr_ts[7:0] = in_word.pdu_byte;
    end
  end

  assign stream_eq = hdr_sid == cfg.stream_id;
  assign size_ok   = (cfg.sample_bytes >= 3'd2) && (cfg.sample_bytes <= 3'd4);
  assign codes_ok  = size_ok &&
                     (hdr[avtpad_pkg::OFS_FORMAT] == {2'b00, cfg.sample_bytes, 3'b000}) &&
                     (hdr[avtpad_pkg::OFS_RATE] == {4'b0000, cfg.rate_code});

  assign acc_now       = hdr_done ? (stream_eq && codes_ok) : hdr_acc;
  assign stream_ok_now = hdr_done ? stream_eq : hdr_stream_ok;

  // sample assembly
  assign pay      = active && !in_hdr && hdr_acc && size_ok;
  assign bis_inc  = {1'b0, bis} + 3'd1;
  assign smp_done = pay && (bis_inc >= cfg.sample_bytes);
  assign smp_word = {smp_acc, in_word.pdu_byte};

  always_comb begin
    case (cfg.sample_bytes)
      3'd2:    smp_val = {{16{smp_word[15]}}, smp_word[15:0]};
      3'd3:    smp_val = {{8{smp_word[23]}}, smp_word[23:0]};
      default: smp_val = smp_word;
    endcase
  end

  assign bis_next     = pay ? (smp_done ? 2'd0 : bis_inc[1:0]) : bis;
  assign smp_acc_next = pay ? (smp_done ? 24'd0 : {smp_acc[15:0], in_word.pdu_byte}) : smp_acc;
  assign cnt_next     = smp_done ? cnt + 10'd1 : cnt;

  // end-of-packet status
  assign short_pkt = pos_next < avtpad_pkg::pos_t'(avtpad_pkg::HDR_BYTES);
  assign detail    = !short_pkt && acc_now;

  always_comb begin
    if (short_pkt) begin
      code = avtpad_pkg::STS_SHORT;
    end else if (!acc_now) begin
      code = stream_ok_now ? avtpad_pkg::STS_CODES : avtpad_pkg::STS_STREAM;
    end else if (bis_next != 2'd0) begin
      code = avtpad_pkg::STS_MISALIGN;
    end else if (cnt_next == 10'd0) begin
      code = avtpad_pkg::STS_EMPTY;
    end else begin
      code = avtpad_pkg::STS_OK;
    end
  end

  always_comb begin
    bndl          = '0;
    bndl.smp_v    = smp_done;
    bndl.smp_val  = smp_val;
    bndl.smp_last = !in_word.last_byte;
    bndl.sts_v    = in_word.last_byte;
    bndl.code     = code;
    bndl.now      = in_word.now_ns;
    if (detail) begin
      bndl.seq_gap = hdr[avtpad_pkg::OFS_SEQ] != exp_seq;
      bndl.ts_bad  = !hdr[avtpad_pkg::OFS_FLAGS][avtpad_pkg::TS_VALID_BIT] ||
                     (hdr_ts == 64'd0);
      bndl.ts      = hdr_ts;
      bndl.cnt     = cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && active && in_hdr) begin
      hdr[pos[avtpad_pkg::HDR_AW-1:0]] <= in_word.pdu_byte;
    end
    p1 <= bndl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      hdr_acc       <= 1'b0;
      hdr_stream_ok <= 1'b0;
      smp_acc       <= '0;
      bis           <= '0;
      cnt           <= '0;
      exp_seq       <= '0;
      p1_v          <= 1'b0;
    end else begin
      p1_v <= acc && (smp_done || in_word.last_byte);
      if (acc) begin
        if (in_word.last_byte) begin
          pos           <= '0;
          hdr_acc       <= 1'b0;
          hdr_stream_ok <= 1'b0;
          smp_acc       <= '0;
          bis           <= '0;
          cnt           <= '0;
          if (detail) begin
            exp_seq <= hdr[avtpad_pkg::OFS_SEQ] + 8'd1;
          end
        end else begin
          pos           <= pos_next;
          hdr_acc       <= acc_now;
          hdr_stream_ok <= stream_ok_now;
          smp_acc       <= smp_acc_next;
          bis           <= bis_next;
          cnt           <= cnt_next;
        end
      end
    end
  end

endmodule

FILE: test/avtpad_result_checker.sv
`timescale 1ns / 1ps

module avtpad_result_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  avtpad_pkg::in_word_t  in_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  avtpad_pkg::out_word_t out_word,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  avtpad_pkg::cfg_idx_t  cfg_index,
  input  logic [63:0]           cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    words_checked
);
  import avtpad_pkg::*;

  // register copies
  logic [63:0] exp_stream;
  logic [2:0]  smp_bytes;
  logic [3:0]  exp_rate;
  logic [19:0] offset_us;

  // packet parsing state
  pos_t        byte_pos;
  logic [7:0]  hdr [HDR_BYTES];
  logic        hdr_ok;
  logic [31:0] smp_acc;
  int unsigned smp_fill;
  logic [9:0]  smp_total;
  logic [7:0]  seq_expect;
  logic [62:0] lat_max;
  logic [62:0] lat_min;

  out_word_t   expected_words[$];
  int          err_cnt = 0;
  int          seen_cnt = 0;

  function automatic logic [63:0] hdr_field64(input int ofs);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) v = {v[55:0], hdr[ofs + i]};
    return v;
  endfunction

  function automatic logic width_ok();
    return smp_bytes >= 3'd2 && smp_bytes <= 3'd4;
  endfunction

  task automatic clear_packet();
    byte_pos  = '0;
    hdr_ok    = 1'b0;
    smp_acc   = '0;
    smp_fill  = 0;
    smp_total = '0;
  endtask

  task automatic reset_model();
    exp_stream = '0;
    smp_bytes  = 3'd3;
    exp_rate   = 4'd5;
    offset_us  = 20'd2000;
    clear_packet();
    seq_expect = '0;
    lat_max    = '0;
    lat_min    = LAT_MAX;
    expected_words.delete();
  endtask

  task automatic depacketize_byte(input in_word_t w);
    out_word_t   r;
    logic [63:0] ts;
    logic [63:0] lat;
    logic [63:0] mag;
    logic [63:0] thr;
    pos_t        payload;
    if (byte_pos < MAX_PDU_BYTES) begin
      if (byte_pos < HDR_BYTES) begin
        hdr[byte_pos] = w.pdu_byte;
        if (byte_pos == HDR_BYTES - 1) begin
          hdr_ok = hdr_field64(OFS_STREAM) == exp_stream && width_ok() &&
                   hdr[OFS_FORMAT] == {2'b00, smp_bytes, 3'b000} &&
                   hdr[OFS_RATE] == {4'b0000, exp_rate};
        end
      end else if (hdr_ok && width_ok()) begin
        smp_acc = {smp_acc[23:0], w.pdu_byte};
        smp_fill++;
        if (smp_fill >= smp_bytes) begin
          r = '0;
          case (smp_bytes)
            3'd2: r.sample_value = {{16{smp_acc[15]}}, smp_acc[15:0]};
            3'd3: r.sample_value = {{8{smp_acc[23]}}, smp_acc[23:0]};
            default: r.sample_value = smp_acc;
          endcase
          r.last_result = !w.last_byte;
          expected_words.push_back(r);
          smp_acc   = '0;
          smp_fill  = 0;
          smp_total = smp_total + 10'd1;
        end
      end
      byte_pos = byte_pos + 1'b1;
    end

    if (w.last_byte) begin
      r = '0;
      r.is_status = 1'b1;
      if (byte_pos < HDR_BYTES) begin
        r.status_code = STS_SHORT;
      end else if (!hdr_ok) begin
        r.status_code = (hdr_field64(OFS_STREAM) == exp_stream) ? STS_CODES : STS_STREAM;
      end else begin
        ts      = hdr_field64(OFS_TS);
        payload = byte_pos - pos_t'(HDR_BYTES);
        lat     = '0;
        r.sequence_gap  = hdr[OFS_SEQ] != seq_expect;
        seq_expect      = hdr[OFS_SEQ] + 8'd1;
        r.timestamp_bad = !hdr[OFS_FLAGS][TS_VALID_BIT] || ts == '0;
        if (ts != '0) begin
          thr = 64'(offset_us) * 64'(THR_SCALE);
          lat = w.now_ns - ts;
          if (!lat[63]) begin
            if (lat[62:0] > lat_max) lat_max = lat[62:0];
            if (lat[62:0] < lat_min) lat_min = lat[62:0];
            mag = lat;
          end else begin
            mag = 64'd0 - lat;
          end
          r.skew_event = mag > thr;
        end
        r.latency_ns       = lat;
        r.sample_count     = smp_total;
        r.packet_timestamp = ts;
        if (!width_ok() || payload % smp_bytes != 0) r.status_code = STS_MISALIGN;
        else if (payload == 0) r.status_code = STS_EMPTY;
        else r.status_code = STS_OK;
      end
      r.max_latency_ns = lat_max;
      r.min_latency_ns = lat_min;
      r.last_result    = 1'b1;
      expected_words.push_back(r);
      clear_packet();
    end
  endtask

  task automatic compare_word(input out_word_t got);
    out_word_t want;
    seen_cnt++;
    if (expected_words.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10) $display("result word %0d arrived with none pending: %h", seen_cnt, got);
      return;
    end
    want = expected_words.pop_front();
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= 10) begin
        $display("result word %0d mismatch (expected/actual):", seen_cnt);
        $display("  status %0d/%0d sample %0d/%0d code %0d/%0d gap %0d/%0d tsbad %0d/%0d",
                 want.is_status, got.is_status, want.sample_value, got.sample_value,
                 want.status_code, got.status_code, want.sequence_gap, got.sequence_gap,
                 want.timestamp_bad, got.timestamp_bad);
        $display("  skew %0d/%0d latency %0d/%0d max %0d/%0d min %0d/%0d",
                 want.skew_event, got.skew_event, want.latency_ns, got.latency_ns,
                 want.max_latency_ns, got.max_latency_ns,
                 want.min_latency_ns, got.min_latency_ns);
        $display("  count %0d/%0d ts %h/%h last %0d/%0d",
                 want.sample_count, got.sample_count, want.packet_timestamp,
                 got.packet_timestamp, want.last_result, got.last_result);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STREAM_ID:    exp_stream = cfg_data;
          CFG_SAMPLE_BYTES: smp_bytes  = cfg_data[2:0];
          CFG_RATE_CODE:    exp_rate   = cfg_data[3:0];
          CFG_PRES_OFFSET:  offset_us  = cfg_data[19:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) compare_word(out_word);
      if (in_valid && !in_stall) depacketize_byte(in_word);
    end
    mismatches    <= err_cnt;
    outstanding   <= expected_words.size();
    words_checked <= seen_cnt;
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import avtpad_pkg::*;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_idx_t  cfg_index;
  logic [63:0] cfg_data;

  int mismatches;
  int outstanding;
  int words_checked;

  // what the stimulus believes the registers hold
  logic [63:0] cfg_sid;
  logic [2:0]  cfg_sb;
  logic [3:0]  cfg_rc;
  logic [19:0] cfg_po;
  logic [7:0]  seq_next;

  logic [7:0]  pdu[$];
  int          send_idle_pct;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  int          bytes_sent = 0;
  int          packets_sent = 0;
  int          settings_used = 1;

  avtp_audio_depacketizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  avtpad_result_checker results_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("avtp_audio_depacketizer_unit verification failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = 80;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic [63:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= {b, lst, now};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_pdu(input logic [63:0] now);
    int n;
    n = pdu.size();
    for (int i = 0; i < n; i++)
      send_byte(pdu[i], i == n - 1, (i == n - 1) ? now : {$urandom, $urandom});
    packets_sent++;
  endtask

  task automatic add_be64(input logic [63:0] v);
    for (int i = 7; i >= 0; i--) pdu.push_back(v[8*i +: 8]);
  endtask

  task automatic add_header(input logic [63:0] sid, input logic [7:0] fmt, rate, flags, seq,
                            input logic [63:0] ts);
    pdu.delete();
    for (int i = 0; i < OFS_STREAM; i++) pdu.push_back(8'($urandom));
    add_be64(sid);
    pdu.push_back(fmt);
    pdu.push_back(rate);
    pdu.push_back(flags);
    pdu.push_back(seq);
    add_be64(ts);
  endtask

  task automatic add_payload(input int n);
    for (int i = 0; i < n; i++) pdu.push_back(8'($urandom));
  endtask

  // drops in_valid and waits until no expected word is outstanding: lets the pipeline and queue empty out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(input logic [63:0] sid, input logic [2:0] sb,
                             input logic [3:0] rc, input logic [19:0] po);
    // upper bits of the narrow registers carry junk
    put_reg(CFG_STREAM_ID, sid);
    put_reg(CFG_SAMPLE_BYTES, {$urandom, 29'($urandom), sb});
    put_reg(CFG_RATE_CODE, {$urandom, 28'($urandom), rc});
    put_reg(CFG_PRES_OFFSET, {$urandom, 12'($urandom), po});
    cfg_valid <= 1'b0;
    cfg_sid = sid;
    cfg_sb  = sb;
    cfg_rc  = rc;
    cfg_po  = po;
    settings_used++;
  endtask

  task automatic random_packet();
    int          pick;
    int          nsmp;
    int          extra;
    logic [63:0] now;
    logic [63:0] ts;
    logic [63:0] thr;
    logic [7:0]  seq;
    logic [7:0]  flags;
    logic [7:0]  fmt;
    logic [7:0]  rate;
    pick = $urandom_range(99);
    now  = {$urandom, $urandom};
    thr  = 64'(cfg_po) * 2000;
    case ($urandom_range(9))
      0: ts = '0;
      1: ts = {$urandom, $urandom};
      2: ts = now + {$urandom, $urandom} % (thr + 2);
      3: ts = now - $urandom_range(16);
      default: ts = now - {$urandom, $urandom} % (2 * thr + 2);
    endcase
    seq   = ($urandom_range(9) == 0) ? 8'($urandom) : seq_next;
    flags = 8'($urandom);
    if ($urandom_range(9) != 0) flags[TS_VALID_BIT] = 1'b1;
    fmt   = {2'b00, cfg_sb, 3'b000};
    rate  = {4'b0000, cfg_rc};
    nsmp  = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
    extra = (cfg_sb > 1) ? $urandom_range(1, cfg_sb - 1) : 1;
    if (pick < 10) begin
      // runt: ends inside the header
      pdu.delete();
      add_payload($urandom_range(1, HDR_BYTES - 1));
    end else if (pick < 17) begin
      add_header(cfg_sid ^ (64'd1 << $urandom_range(63)), fmt, rate, flags, seq, ts);
      add_payload($urandom_range(0, 20));
    end else if (pick < 24) begin
      if ($urandom_range(1)) fmt = fmt ^ 8'(1 << $urandom_range(7));
      else rate = rate ^ 8'(1 << $urandom_range(7));
      add_header(cfg_sid, fmt, rate, flags, seq, ts);
      add_payload($urandom_range(0, 20));
    end else begin
      add_header(cfg_sid, fmt, rate, flags, seq, ts);
      add_payload(nsmp * cfg_sb + ((pick < 32) ? extra : 0));
      seq_next = seq + 8'd1;
    end
    send_pdu(now);
  endtask

  initial begin
    int phase_start;
    int budget;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_STREAM_ID;
    cfg_data  = '0;
    send_idle_pct = 0;
    cfg_sid  = '0;
    cfg_sb   = 3'd3;
    cfg_rc   = 4'd5;
    cfg_po   = 20'd2000;
    seq_next = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // runt of a single byte
    pdu.delete();
    pdu.push_back(8'hFF);
    send_pdu('0);
    // invalid zero timestamp, extreme samples, last byte also ends a sample
    add_header('0, 8'd24, 8'd5, 8'h00, 8'd0, '0);
    pdu.push_back(8'h80); pdu.push_back(8'h00); pdu.push_back(8'h00);
    pdu.push_back(8'h7F); pdu.push_back(8'hFF); pdu.push_back(8'hFF);
    send_pdu(64'hFFFF_FFFF_FFFF_FFFF);
    // empty payload, latency at the top of the time range
    add_header('0, 8'd24, 8'd5, 8'h80, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF - 64'd1000);
    send_pdu(64'hFFFF_FFFF_FFFF_FFFF);
    // sequence jump, negative latency past the skew limit, misaligned payload
    add_header('0, 8'd24, 8'd5, 8'hFF, 8'd5, 64'd5_000_000);
    pdu.push_back(8'hFF); pdu.push_back(8'hFF); pdu.push_back(8'hFF); pdu.push_back(8'h00);
    send_pdu('0);
    seq_next = 8'd6;
    add_header(64'hFFFF_FFFF_FFFF_FFFF, 8'd24, 8'd5, 8'h80, 8'd6, 64'd1);
    add_payload(3);
    send_pdu(64'd2);
    add_header('0, 8'd24, 8'd4, 8'h80, 8'd6, 64'd1);
    send_pdu(64'd2);

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      case (ph)
        1: load_config(64'hFFFF_FFFF_FFFF_FFFF, 3'd2, 4'd1, 20'd0);
        2: load_config({$urandom, $urandom}, 3'd4, 4'd9, 20'd1000000);
        3: load_config('0, 3'd3, 4'd15, 20'hFFFFF);
        4: load_config({$urandom, $urandom}, 3'd7, 4'd5, 20'd2000);
        5: load_config({$urandom, $urandom}, 3'd0, 4'd0, 20'd500);
        6: load_config({$urandom, $urandom}, 3'd4, 4'($urandom_range(1, 9)),
                       20'($urandom_range(0, 1000000)));
        default: ;
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 61; end
        default: begin send_idle_pct = 36; recv_stall_pct <= 36; end
      endcase
      // receiver holds off while bytes keep coming, so the block backs up
      if (ph == 0) hold_req <= hold_req + 1;
      budget      = (ph == 4 || ph == 5) ? 60 : 120;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < budget / 2) random_packet();
      wait_idle();
      while (bytes_sent - phase_start < budget) random_packet();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("run covered %0d packets (%0d bytes) over %0d register settings,",
             packets_sent, bytes_sent, settings_used);
    $display("incl. bad sample sizes, rejected headers and receiver back-pressure; %0d words checked",
             words_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("avtp_audio_depacketizer_unit verification clean");
    end else begin
      $display("avtp_audio_depacketizer_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/avtpad_pkg.sv
hw/rtl/avtpad_front.sv
hw/rtl/avtp_audio_depacketizer_unit.sv
test/avtpad_result_checker.sv
test/tb.sv
